// File: src/eqmm_pkg.sv
package eqmm_pkg;

  localparam int BOARD_SIZE = 8;
  localparam int ROW_W      = $clog2(BOARD_SIZE);
  localparam int COL_W      = $clog2(BOARD_SIZE + 1);
  localparam int COST_W     = $clog2(BOARD_SIZE + 1);

  localparam logic [COL_W-1:0]  LAST_COL  = COL_W'(BOARD_SIZE - 1);
  localparam logic [COL_W-1:0]  END_COL   = COL_W'(BOARD_SIZE);
  localparam logic [COL_W-1:0]  ROW_LIMIT = COL_W'(BOARD_SIZE);
  localparam logic [COST_W-1:0] WORST     = COST_W'(BOARD_SIZE);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_DONE
  } eqmm_state_t;

  typedef struct packed {
    logic load;
    logic step;
  } eqmm_cmd_t;

  typedef struct packed {
    logic exhausted;
  } eqmm_status_t;

endpackage

// File: src/eqmm_ctrl.sv
module eqmm_ctrl (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  input  eqmm_pkg::eqmm_status_t status,
  output eqmm_pkg::eqmm_cmd_t   cmd,
  output logic                  busy,
  output logic                  done
);
  import eqmm_pkg::*;

  eqmm_state_t state_r;
  eqmm_state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (start) state_nxt = ST_SEARCH;
      end
      ST_SEARCH: begin
        if (status.exhausted) state_nxt = ST_DONE;
      end
      ST_DONE: begin
        state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd  = '0;
    busy = 1'b1;
    done = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        busy     = 1'b0;
        cmd.load = start;
      end
      ST_SEARCH: begin
        cmd.step = 1'b1;
      end
      ST_DONE: begin
        done = 1'b1;
      end
      default: busy = 1'b1;
    endcase
  end

endmodule

// File: src/eqmm_datapath.sv
module eqmm_datapath (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  eqmm_pkg::eqmm_cmd_t                    cmd,
  input  logic [eqmm_pkg::BOARD_SIZE*eqmm_pkg::ROW_W-1:0] start_rows,
  output eqmm_pkg::eqmm_status_t                 status,
  output logic [eqmm_pkg::COST_W-1:0]            best_cost
);
  import eqmm_pkg::*;

  logic [ROW_W-1:0]  start_r    [BOARD_SIZE];
  logic [ROW_W-1:0]  placed_r   [BOARD_SIZE];
  logic [COL_W-1:0]  next_row_r [BOARD_SIZE];
  logic [BOARD_SIZE-1:0] moved_r;
  logic [COL_W-1:0]  col_r, col_nxt;
  logic [COST_W-1:0] cost_r, cost_nxt;
  logic [COST_W-1:0] best_r, best_nxt;

  logic [ROW_W-1:0]      cur_idx;
  logic [ROW_W-1:0]      back_idx;
  logic [COL_W-1:0]      cand;
  logic [ROW_W-1:0]      cand_row;
  logic                  at_end;
  logic                  tried_all;
  logic [BOARD_SIZE-1:0] hit;
  logic                  free;
  logic                  do_place;
  logic                  do_back;

  assign cur_idx   = col_r[ROW_W-1:0];
  assign at_end    = (col_r == END_COL);
  assign cand      = next_row_r[cur_idx];
  assign cand_row  = cand[ROW_W-1:0];
  assign tried_all = (cand >= ROW_LIMIT);

  // Queens already placed in columns left of the current one; a row or diagonal hit blocks it.
  always_comb begin
    logic [ROW_W-1:0] dr;
    logic [COL_W-1:0] dc;
    for (int k = 0; k < BOARD_SIZE; k++) begin
      dr = (cand_row > placed_r[k]) ? (cand_row - placed_r[k]) : (placed_r[k] - cand_row);
      dc = col_r - COL_W'(k);
      hit[k] = (COL_W'(k) < col_r) && ((dr == '0) || ({1'b0, dr} == dc));
    end
  end
  assign free = ~|hit;

  assign do_place = cmd.step && !at_end && !tried_all && free;
  assign do_back  = cmd.step && (at_end || (tried_all && (col_r != '0)));
  assign back_idx = at_end ? LAST_COL[ROW_W-1:0] : (cur_idx - ROW_W'(1));

  assign status.exhausted = !at_end && tried_all && (col_r == '0);
  assign best_cost        = best_r;

  always_comb begin
    col_nxt  = col_r;
    cost_nxt = cost_r;
    best_nxt = best_r;
    if (cmd.load) begin
      col_nxt  = '0;
      cost_nxt = '0;
      best_nxt = WORST;
    end else if (do_back) begin
      if (at_end && (cost_r < best_r)) best_nxt = cost_r;
      col_nxt = {1'b0, back_idx};
      if (moved_r[back_idx]) cost_nxt = cost_r - COST_W'(1);
    end else if (do_place) begin
      col_nxt = col_r + COL_W'(1);
      if (cand_row != start_r[cur_idx]) cost_nxt = cost_r + COST_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r  <= '0;
      cost_r <= '0;
      best_r <= WORST;
    end else begin
      col_r  <= col_nxt;
      cost_r <= cost_nxt;
      best_r <= best_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      for (int k = 0; k < BOARD_SIZE; k++) begin
        start_r[k] <= start_rows[k*ROW_W +: ROW_W];
      end
      next_row_r[0] <= '0;
    end else if (cmd.step && !at_end && !tried_all) begin
      next_row_r[cur_idx] <= cand + COL_W'(1);
      if (free) begin
        placed_r[cur_idx] <= cand_row;
        moved_r[cur_idx]  <= (cand_row != start_r[cur_idx]);
        if (col_r != LAST_COL) next_row_r[cur_idx + ROW_W'(1)] <= '0;
      end
    end
  end

endmodule

// File: src/eight_queens_min_moves.sv
// Eight queens, fewest moves. Pulse start while busy is low to hand over one board: the row
// (row number minus one) of the single queen in each of the eight columns. The block then
// runs a complete depth-first backtracking search over all non-attacking placements and
// reports the fewest queens that must move within their own columns. The search takes one
// step per clock. In each step it tries the next row of the current column, with all
// conflict checks against the earlier columns running in parallel, and advances a column
// when that row is free. Otherwise it backs up one column once every row has been tried.
// The search tree does not depend on the board. Each of the 1,965 partial placements of up
// to seven queens tries each of its eight rows in turn and then backs out, or finishes the
// search. Each of the 92 complete placements is scored and then backed out of.
// The result appears on out_min_moves with out_valid high for exactly one cycle right after
// the search. The receiver cannot stall it, so it must take the transfer in that cycle.
// busy stays high from the accepted start until that result cycle is over. The next board
// can be accepted at the end of the cycle after it, so a new board is never taken while a
// search is running.
module eight_queens_min_moves (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       start,
  output logic       busy,
  input  logic [2:0] in_row_col1,
  input  logic [2:0] in_row_col2,
  input  logic [2:0] in_row_col3,
  input  logic [2:0] in_row_col4,
  input  logic [2:0] in_row_col5,
  input  logic [2:0] in_row_col6,
  input  logic [2:0] in_row_col7,
  input  logic [2:0] in_row_col8,
  output logic       out_valid,
  output logic [3:0] out_min_moves
);
  import eqmm_pkg::*;

  eqmm_cmd_t    cmd;
  eqmm_status_t status;
  logic [BOARD_SIZE*ROW_W-1:0] start_rows;
  logic [COST_W-1:0]           best_cost;

  // Column one sits in the lowest bits of the packed board.
  assign start_rows = {in_row_col8, in_row_col7, in_row_col6, in_row_col5,
                       in_row_col4, in_row_col3, in_row_col2, in_row_col1};

  eqmm_ctrl u_ctrl (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .status (status),
    .cmd    (cmd),
    .busy   (busy),
    .done   (out_valid)
  );

  eqmm_datapath u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .start_rows (start_rows),
    .status     (status),
    .best_cost  (best_cost)
  );

  // The best cost holds still once the search has finished.
  assign out_min_moves = best_cost;

endmodule

// File: src/eqmm_checker.sv
module eqmm_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       start,
  input logic       busy,
  input logic       out_valid,
  input logic [3:0] out_min_moves
);

  a_result_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_min_moves <= 4'd8))
    else $error("result above eight");

  a_result_while_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> busy)
    else $error("result outside a busy period");

  a_start_sets_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("accepted start did not raise busy");

  a_single_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> (!out_valid && !busy))
    else $error("result strobe not followed by idle");

endmodule

bind eight_queens_min_moves eqmm_checker u_eqmm_checker (.*);

// File: bench/tb.sv
`timescale 1ns / 1ps

module tb;
  import eqmm_pkg::*;

  // One board: entry c is the row (minus one) of the queen in column c + 1.
  typedef logic [BOARD_SIZE-1:0][ROW_W-1:0] board_t;

  // A directed row either carries a hand-worked answer or defers to the predictor.
  localparam int FROM_PREDICTOR = -1;

  typedef struct {
    board_t board;
    int     want;
  } board_case_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic [2:0] in_row_col1 = '0;
  logic [2:0] in_row_col2 = '0;
  logic [2:0] in_row_col3 = '0;
  logic [2:0] in_row_col4 = '0;
  logic [2:0] in_row_col5 = '0;
  logic [2:0] in_row_col6 = '0;
  logic [2:0] in_row_col7 = '0;
  logic [2:0] in_row_col8 = '0;
  logic out_valid;
  logic [3:0] out_min_moves;

  // Every non-attacking placement, collected once before the stimulus starts.
  board_t queen_solutions[$];
  // Answers owed by the block, oldest first.
  logic [COST_W-1:0] pending_moves[$];
  board_case_t directed_cases[$];
  int mismatches = 0;

  eight_queens_min_moves i_dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .in_row_col1  (in_row_col1),
    .in_row_col2  (in_row_col2),
    .in_row_col3  (in_row_col3),
    .in_row_col4  (in_row_col4),
    .in_row_col5  (in_row_col5),
    .in_row_col6  (in_row_col6),
    .in_row_col7  (in_row_col7),
    .in_row_col8  (in_row_col8),
    .out_valid    (out_valid),
    .out_min_moves(out_min_moves)
  );

  // A 2 ns clock, with reset held low at the start and then released.
  initial begin
    forever #1 clk = ~clk;
  end

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
  end

  // Safety net: the slowest legal run is well under a third of this.
  initial begin
    #60_000_000;
    $display("** eight_queens_min_moves: FAILED **");
    $finish;
  end

  // Places queens column by column and records every complete placement in which no
  // two queens share a row or a diagonal. Columns past col are still free.
  function automatic void place_queens(input int col, input board_t partial);
    bool_loop: for (int r = 0; r < BOARD_SIZE; r++) begin
      bit attacked;
      attacked = 1'b0;
      for (int k = 0; k < col; k++) begin
        int dr;
        dr = (r > partial[k]) ? r - partial[k] : partial[k] - r;
        if (dr == 0 || dr == col - k) attacked = 1'b1;
      end
      if (!attacked) begin
        partial[col] = ROW_W'(r);
        if (col == BOARD_SIZE - 1) queen_solutions.push_back(partial);
        else place_queens(col + 1, partial);
      end
    end
  endfunction

  // The fewest queens to move is the smallest number of columns in which the board
  // differs from some non-attacking placement. The search can never report more than
  // a full board's worth of moves.
  function automatic logic [COST_W-1:0] fewest_moves(input board_t b);
    int best;
    best = BOARD_SIZE;
    foreach (queen_solutions[s]) begin
      int moved;
      moved = 0;
      for (int c = 0; c < BOARD_SIZE; c++)
        if (queen_solutions[s][c] != b[c]) moved++;
      if (moved < best) best = moved;
    end
    return COST_W'(best);
  endfunction

  // Builds a board from the rows of columns one to eight, written in that order.
  function automatic board_t board_of(input int r1, input int r2, input int r3, input int r4,
                                      input int r5, input int r6, input int r7, input int r8);
    board_t b;
    b[0] = ROW_W'(r1);
    b[1] = ROW_W'(r2);
    b[2] = ROW_W'(r3);
    b[3] = ROW_W'(r4);
    b[4] = ROW_W'(r5);
    b[5] = ROW_W'(r6);
    b[6] = ROW_W'(r7);
    b[7] = ROW_W'(r8);
    return b;
  endfunction

  // Hands one board to the block and records the answer it owes. With a chance of
  // idle_pct in a hundred the sender first drops start for a while: sometimes only a
  // few cycles, which usually lands in the middle of a search, and sometimes until
  // the block is free plus a few more, so that the gap also covers the hand-over.
  // Start otherwise stays high from one transfer to the next without a dip.
  task automatic send_board(input board_t b, input int want, input int idle_pct);
    if ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      if ($urandom_range(1)) begin
        repeat ($urandom_range(1, 4)) @(posedge clk);
      end else begin
        @(posedge clk);
        while (busy) @(posedge clk);
        repeat ($urandom_range(0, 3)) @(posedge clk);
      end
    end
    start       <= 1'b1;
    in_row_col1 <= b[0];
    in_row_col2 <= b[1];
    in_row_col3 <= b[2];
    in_row_col4 <= b[3];
    in_row_col5 <= b[4];
    in_row_col6 <= b[5];
    in_row_col7 <= b[6];
    in_row_col8 <= b[7];
    // The transfer happens at the first edge at which busy was low.
    @(posedge clk);
    while (busy) @(posedge clk);
    if (want == FROM_PREDICTOR) pending_moves.push_back(fewest_moves(b));
    else pending_moves.push_back(COST_W'(want));
  endtask

  // Result side: the block cannot be stalled, so each strobe is one transfer and is
  // matched against the oldest answer owed. Values are sampled at the edge that ends
  // the result cycle.
  always @(posedge clk) begin
    logic [COST_W-1:0] want;
    if (rst_n && out_valid) begin
      if (pending_moves.size() == 0) begin
        $display("%0t: result with none owed: expected nothing, got %0d",
                 $time, out_min_moves);
        mismatches++;
      end else begin
        want = pending_moves.pop_front();
        if (out_min_moves !== want) begin
          $display("%0t: min_moves mismatch: expected %0d, got %0d",
                   $time, want, out_min_moves);
          mismatches++;
        end
      end
    end
  end

  // Stimulus: a short directed table, then random boards in phases of sender idling.
  initial begin
    board_t b;
    int     idle_pct[4];
    int     kind;

    place_queens(0, '0);

    // Boards with every queen on one row: each placement has exactly one queen on
    // that row, so seven queens must move.
    directed_cases.push_back('{board_of(0, 0, 0, 0, 0, 0, 0, 0), 7});
    directed_cases.push_back('{board_of(7, 7, 7, 7, 7, 7, 7, 7), 7});
    directed_cases.push_back('{board_of(3, 3, 3, 3, 3, 3, 3, 3), 7});
    // Boards that already are non-attacking placements, and one with a single queen
    // pulled off such a placement.
    directed_cases.push_back('{board_of(0, 4, 7, 5, 2, 6, 1, 3), 0});
    directed_cases.push_back('{board_of(7, 3, 0, 2, 5, 1, 6, 4), 0});
    directed_cases.push_back('{board_of(3, 1, 6, 2, 5, 7, 4, 0), 0});
    directed_cases.push_back('{board_of(1, 4, 7, 5, 2, 6, 1, 3), 1});
    // Diagonals, alternating extremes and mixed patterns go to the predictor.
    directed_cases.push_back('{board_of(0, 1, 2, 3, 4, 5, 6, 7), FROM_PREDICTOR});
    directed_cases.push_back('{board_of(7, 6, 5, 4, 3, 2, 1, 0), FROM_PREDICTOR});
    directed_cases.push_back('{board_of(0, 7, 0, 7, 0, 7, 0, 7), FROM_PREDICTOR});
    directed_cases.push_back('{board_of(7, 0, 7, 0, 7, 0, 7, 0), FROM_PREDICTOR});
    directed_cases.push_back('{board_of(5, 2, 5, 2, 5, 2, 5, 2), FROM_PREDICTOR});
    directed_cases.push_back('{board_of(1, 6, 3, 4, 0, 7, 2, 5), FROM_PREDICTOR});
    directed_cases.push_back('{board_of(0, 0, 0, 0, 7, 7, 7, 7), FROM_PREDICTOR});
    directed_cases.push_back('{board_of(4, 4, 7, 5, 2, 6, 1, 3), FROM_PREDICTOR});

    while (!rst_n) @(posedge clk);

    foreach (directed_cases[i])
      send_board(directed_cases[i].board, directed_cases[i].want, 0);

    // Phases: no idling, the sender idle often, idle now and then, then no idling again.
    idle_pct = '{0, 57, 35, 0};
    foreach (idle_pct[p]) begin
      for (int n = 0; n < 66; n++) begin
        kind = $urandom_range(99);
        if (kind < 50) begin
          // A placement with a few queens disturbed keeps the answer small, where the
          // search has to find the one close placement among many far ones.
          b = queen_solutions[$urandom_range(queen_solutions.size() - 1)];
          repeat ($urandom_range(0, 4)) b[$urandom_range(BOARD_SIZE - 1)] = ROW_W'($urandom_range(7));
        end else begin
          for (int c = 0; c < BOARD_SIZE; c++) b[c] = ROW_W'($urandom_range(7));
        end
        send_board(b, FROM_PREDICTOR, idle_pct[p]);
      end
    end

    start <= 1'b0;
    while (pending_moves.size() != 0) @(posedge clk);
    // Leave room for a stray result from a search that should never have started.
    repeat (20000) @(posedge clk);

    if (mismatches == 0 && pending_moves.size() == 0) begin
      $display("** eight_queens_min_moves: PASSED **");
    end else begin
      $display("** eight_queens_min_moves: FAILED **");
    end
    $finish;
  end

endmodule
